FILE: hdl/ioirq_pkg.sv
// Package: operation and register codes, state record and constants of the I/O chip register file.
`default_nettype none
package ioirq_pkg;

    localparam int OP_W   = 3;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 8;
    localparam int CNT_W  = 7;

    localparam logic [OP_W-1:0] OP_READ  = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd2;
    localparam logic [OP_W-1:0] OP_KEY   = 3'd3;
    localparam logic [OP_W-1:0] OP_BREAK = 3'd4;

    localparam logic [ADDR_W-1:0] REG_POT0   = 4'd0;
    localparam logic [ADDR_W-1:0] REG_POT1   = 4'd1;
    localparam logic [ADDR_W-1:0] REG_POT2   = 4'd2;
    localparam logic [ADDR_W-1:0] REG_POT5   = 4'd5;
    localparam logic [ADDR_W-1:0] REG_ALLPOT = 4'd8;
    localparam logic [ADDR_W-1:0] REG_KBCODE = 4'd9;
    localparam logic [ADDR_W-1:0] REG_RANDOM = 4'd10;
    localparam logic [ADDR_W-1:0] REG_SKREST = 4'd10;
    localparam logic [ADDR_W-1:0] REG_SEROUT = 4'd13;
    localparam logic [ADDR_W-1:0] REG_IRQST  = 4'd14;
    localparam logic [ADDR_W-1:0] REG_IRQEN  = 4'd14;
    localparam logic [ADDR_W-1:0] REG_SKSTAT = 4'd15;
    localparam logic [ADDR_W-1:0] REG_SKCTL  = 4'd15;

    localparam logic [DATA_W-1:0] IRQST_RESET  = 8'hF7;
    localparam logic [DATA_W-1:0] IRQST_KEEP   = 8'hF7;
    localparam logic [DATA_W-1:0] SKSTAT_RESET = 8'hFF;
    localparam logic [DATA_W-1:0] FLOAT_READ   = 8'hFF;
    localparam logic [1:0]        SKCTL_RESET_MODE = 2'b00;

    localparam int IRQ_BREAK_BIT = 7;
    localparam int IRQ_KEY_BIT   = 6;
    localparam int IRQ_OUTRDY_BIT = 4;
    localparam int IRQ_XMIT_BIT  = 3;

    typedef struct packed {
        logic [DATA_W-1:0] serial_control;
        logic [DATA_W-1:0] serial_status;
        logic [DATA_W-1:0] irq_enable;
        logic [DATA_W-1:0] irq_status;
        logic [DATA_W-1:0] key_code;
        logic [DATA_W-1:0] random_byte;
        logic [CNT_W-1:0]  out_ready_count;
        logic [CNT_W-1:0]  xmit_done_count;
        logic              irq_line;
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] register_address;
        logic [DATA_W-1:0] item_data;
    } request_t;

endpackage
`default_nettype wire

FILE: hdl/ioirq_if.sv
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none
interface ioirq_req_if;
    logic                          valid;
    logic                          ready;
    logic [ioirq_pkg::OP_W-1:0]    operation;
    logic [ioirq_pkg::ADDR_W-1:0]  register_address;
    logic [ioirq_pkg::DATA_W-1:0]  item_data;

    modport source (output valid, output operation, output register_address,
                    output item_data, input ready);
    modport sink   (input valid, input operation, input register_address,
                    input item_data, output ready);
endinterface

interface ioirq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ioirq_pkg::DATA_W-1:0]  read_data;
    logic                          irq_out;

    modport source (output valid, output read_data, output irq_out, input ready);
    modport sink   (input valid, input read_data, input irq_out, output ready);
endinterface
`default_nettype wire

FILE: hdl/ioirq_core.sv
// Next-state and read-data logic for one request against the register file state.
`default_nettype none
module ioirq_core #(
    parameter int SERIAL_DELAY_TICKS = 100
) (
    input  wire ioirq_pkg::state_t               state,
    input  wire ioirq_pkg::request_t             request,
    output ioirq_pkg::state_t                    state_next,
    output logic [ioirq_pkg::DATA_W-1:0]         read_data
);

    localparam logic [ioirq_pkg::CNT_W-1:0] DELAY_LOAD =
        ioirq_pkg::CNT_W'(SERIAL_DELAY_TICKS);

    always_comb
    begin
        logic [ioirq_pkg::DATA_W-1:0] d;
        logic [ioirq_pkg::DATA_W-1:0] status_set;
        d          = request.item_data;
        status_set = state.irq_status | (~d & ioirq_pkg::IRQST_KEEP);
        state_next = state;
        read_data  = '0;
        unique case (request.operation)
            ioirq_pkg::OP_READ:
            begin
                unique case (request.register_address) inside
                    ioirq_pkg::REG_POT0, ioirq_pkg::REG_POT1, ioirq_pkg::REG_POT2,
                    ioirq_pkg::REG_POT5, ioirq_pkg::REG_ALLPOT:
                        read_data = '0;
                    ioirq_pkg::REG_KBCODE:
                        read_data = state.key_code;
                    ioirq_pkg::REG_RANDOM:
                    begin
                        read_data = state.random_byte;
                        state_next.random_byte = state.random_byte + 1'b1;
                    end
                    ioirq_pkg::REG_IRQST:
                        read_data = state.irq_status;
                    ioirq_pkg::REG_SKSTAT:
                        read_data = state.serial_status;
                    default:
                        read_data = ioirq_pkg::FLOAT_READ;
                endcase
            end
            ioirq_pkg::OP_WRITE:
            begin
                unique case (request.register_address)
                    ioirq_pkg::REG_SKREST:
                        state_next.serial_status = ioirq_pkg::SKSTAT_RESET;
                    ioirq_pkg::REG_SEROUT:
                    begin
                        state_next.out_ready_count = DELAY_LOAD;
                        state_next.xmit_done_count = DELAY_LOAD;
                        state_next.irq_status[ioirq_pkg::IRQ_XMIT_BIT] = 1'b1;
                    end
                    ioirq_pkg::REG_IRQEN:
                    begin
                        state_next.irq_enable = d;
                        state_next.irq_status = status_set;
                        state_next.irq_line   = |(d & ~status_set);
                    end
                    ioirq_pkg::REG_SKCTL:
                    begin
                        state_next.serial_control = d;
                        if (d[1:0] == ioirq_pkg::SKCTL_RESET_MODE)
                        begin
                            state_next.serial_control  = '0;
                            state_next.serial_status   = ioirq_pkg::SKSTAT_RESET;
                            state_next.irq_enable      = '0;
                            state_next.irq_status      = ioirq_pkg::IRQST_RESET;
                            state_next.random_byte     = '0;
                            state_next.out_ready_count = '0;
                            state_next.xmit_done_count = '0;
                        end
                    end
                    default:
                        state_next = state;
                endcase
            end
            ioirq_pkg::OP_TICK:
            begin
                if (state.serial_control[1:0] != ioirq_pkg::SKCTL_RESET_MODE)
                begin
                    if (state.out_ready_count != '0)
                    begin
                        state_next.out_ready_count = state.out_ready_count - 1'b1;
                        if (state.out_ready_count == ioirq_pkg::CNT_W'(1) &&
                            state.irq_enable[ioirq_pkg::IRQ_OUTRDY_BIT])
                        begin
                            state_next.irq_status[ioirq_pkg::IRQ_OUTRDY_BIT] = 1'b0;
                            state_next.irq_line = 1'b1;
                        end
                    end
                    if (state.xmit_done_count != '0)
                    begin
                        state_next.xmit_done_count = state.xmit_done_count - 1'b1;
                        if (state.xmit_done_count == ioirq_pkg::CNT_W'(1))
                        begin
                            state_next.irq_status[ioirq_pkg::IRQ_XMIT_BIT] = 1'b0;
                            if (state.irq_enable[ioirq_pkg::IRQ_XMIT_BIT])
                            begin
                                state_next.irq_line = 1'b1;
                            end
                        end
                    end
                end
            end
            ioirq_pkg::OP_KEY:
            begin
                state_next.key_code = d;
                if (state.irq_enable[ioirq_pkg::IRQ_KEY_BIT])
                begin
                    state_next.irq_status[ioirq_pkg::IRQ_KEY_BIT] = 1'b0;
                    state_next.irq_line = 1'b1;
                end
            end
            ioirq_pkg::OP_BREAK:
            begin
                if (state.irq_enable[ioirq_pkg::IRQ_BREAK_BIT])
                begin
                    state_next.irq_status[ioirq_pkg::IRQ_BREAK_BIT] = 1'b0;
                    state_next.irq_line = 1'b1;
                end
            end
            default:
                state_next = state;
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/io_chip_irq_register_file.sv
// Top level: I/O chip register file with interrupt enable/status, serial delays and key latch.
// A request is held in the request register and its result in the result register.
// Throughput: one request per cycle unless a full result register waits on rsp.ready.
// State update and read mux sit between them, so back-to-back requests chain through state.
// Reset: rst_n clears the request and result stages and loads all state registers
// with their power-up values (serial status and interrupt status 0xFF and 0xF7).
`default_nettype none
module io_chip_irq_register_file #(
    parameter int SERIAL_DELAY_TICKS = 100
) (
    input  wire         clk,
    input  wire         rst_n,
    ioirq_req_if.sink   req,
    ioirq_rsp_if.source rsp
);

    logic                          stage_valid_reg;
    ioirq_pkg::request_t           stage_req_reg;
    ioirq_pkg::state_t             state_reg;
    ioirq_pkg::state_t             state_next;
    logic [ioirq_pkg::DATA_W-1:0]  read_data_next;
    logic                          out_valid_reg;
    logic [ioirq_pkg::DATA_W-1:0]  out_data_reg;
    logic                          out_irq_reg;
    logic                          stage_fire;
    logic                          req_fire;
    ioirq_pkg::state_t             state_reset;

    assign state_reset = '{
        serial_control:  '0,
        serial_status:   ioirq_pkg::SKSTAT_RESET,
        irq_enable:      '0,
        irq_status:      ioirq_pkg::IRQST_RESET,
        key_code:        '0,
        random_byte:     '0,
        out_ready_count: '0,
        xmit_done_count: '0,
        irq_line:        1'b0
    };

    assign stage_fire = stage_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready  = !stage_valid_reg || stage_fire;
    assign req_fire   = req.valid && req.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.irq_out   = out_irq_reg;

    ioirq_core #(
        .SERIAL_DELAY_TICKS (SERIAL_DELAY_TICKS)
    ) u_core (
        .state      (state_reg),
        .request    (stage_req_reg),
        .state_next (state_next),
        .read_data  (read_data_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= state_reset;
        end
        else
        begin
            if (req.ready)
            begin
                stage_valid_reg <= req.valid;
            end
            if (stage_fire)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            stage_req_reg.operation        <= req.operation;
            stage_req_reg.register_address <= req.register_address;
            stage_req_reg.item_data        <= req.item_data;
        end
        if (stage_fire)
        begin
            out_data_reg <= read_data_next;
            out_irq_reg  <= state_next.irq_line;
        end
    end

    // irq line drops only on an enable register write
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(state_reg.irq_line) |->
            $past(stage_fire && stage_req_reg.operation == ioirq_pkg::OP_WRITE &&
                  stage_req_reg.register_address == ioirq_pkg::REG_IRQEN))
        else $error("irq line dropped without an enable write");

    // serial control reset mode restores status and counters
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && stage_req_reg.operation == ioirq_pkg::OP_WRITE &&
         stage_req_reg.register_address == ioirq_pkg::REG_SKCTL &&
         stage_req_reg.item_data[1:0] == ioirq_pkg::SKCTL_RESET_MODE) |=>
            (state_reg.irq_status == ioirq_pkg::IRQST_RESET &&
             state_reg.out_ready_count == '0 && state_reg.xmit_done_count == '0))
        else $error("block reset did not restore state");

    // an empty result stage never blocks requests
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> req.ready)
        else $error("request stalled with empty result stage");

    // result irq matches the committed state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_irq_reg == state_reg.irq_line))
        else $error("result irq differs from state");

endmodule
`default_nettype wire

FILE: tb/io_chip_irq_register_file_test.sv
// Testbench: random and directed register, tick, key and break requests checked against a predictor.
`default_nettype none
module io_chip_irq_register_file_test;

    localparam int DELAY_TICKS  = 100;
    localparam int RANDOM_ITEMS = 1500;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [ioirq_pkg::OP_W-1:0]   OP_SPARE_FIRST = 3'd5;
    localparam logic [ioirq_pkg::OP_W-1:0]   OP_SPARE_LAST  = 3'd7;
    localparam logic [ioirq_pkg::ADDR_W-1:0] REG_SPARE      = 4'd12;

    typedef struct packed {
        logic [ioirq_pkg::DATA_W-1:0] read_data;
        logic                         irq_out;
    } reply_t;

    logic clk;
    logic rst_n;
    int   accepted_requests;
    int   mismatches;
    int   quiet_cycles;
    logic steady;

    ioirq_pkg::state_t   chip;
    ioirq_pkg::request_t pending_requests[$];
    reply_t              due_replies[$];

    ioirq_req_if req();
    ioirq_rsp_if rsp();

    io_chip_irq_register_file #(
        .SERIAL_DELAY_TICKS(DELAY_TICKS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );

    assign steady = (accepted_requests >= 500) && (accepted_requests < 800);

    function automatic void clear_chip_block();
        chip.serial_control  = '0;
        chip.serial_status   = ioirq_pkg::SKSTAT_RESET;
        chip.irq_enable      = '0;
        chip.irq_status      = ioirq_pkg::IRQST_RESET;
        chip.random_byte     = '0;
        chip.out_ready_count = '0;
        chip.xmit_done_count = '0;
    endfunction

    function automatic reply_t step_chip(ioirq_pkg::request_t r);
        reply_t rep;
        rep.read_data = '0;
        case (r.operation)
            ioirq_pkg::OP_READ:
            begin
                case (r.register_address)
                    ioirq_pkg::REG_POT0, ioirq_pkg::REG_POT1, ioirq_pkg::REG_POT2,
                    ioirq_pkg::REG_POT5, ioirq_pkg::REG_ALLPOT: rep.read_data = '0;
                    ioirq_pkg::REG_KBCODE: rep.read_data = chip.key_code;
                    ioirq_pkg::REG_RANDOM:
                    begin
                        rep.read_data = chip.random_byte;
                        chip.random_byte = chip.random_byte + 8'd1;
                    end
                    ioirq_pkg::REG_IRQST: rep.read_data = chip.irq_status;
                    ioirq_pkg::REG_SKSTAT: rep.read_data = chip.serial_status;
                    default: rep.read_data = ioirq_pkg::FLOAT_READ;
                endcase
            end
            ioirq_pkg::OP_WRITE:
            begin
                case (r.register_address)
                    ioirq_pkg::REG_SKREST: chip.serial_status = ioirq_pkg::SKSTAT_RESET;
                    ioirq_pkg::REG_SEROUT:
                    begin
                        chip.out_ready_count = ioirq_pkg::CNT_W'(DELAY_TICKS);
                        chip.xmit_done_count = ioirq_pkg::CNT_W'(DELAY_TICKS);
                        chip.irq_status[ioirq_pkg::IRQ_XMIT_BIT] = 1'b1;
                    end
                    ioirq_pkg::REG_IRQEN:
                    begin
                        chip.irq_enable = r.item_data;
                        chip.irq_status = chip.irq_status |
                                          (~r.item_data & ioirq_pkg::IRQST_KEEP);
                        chip.irq_line = |(chip.irq_enable & ~chip.irq_status);
                    end
                    ioirq_pkg::REG_SKCTL:
                    begin
                        chip.serial_control = r.item_data;
                        if (r.item_data[1:0] == ioirq_pkg::SKCTL_RESET_MODE)
                            clear_chip_block();
                    end
                    default: ;
                endcase
            end
            ioirq_pkg::OP_TICK:
            begin
                if (chip.serial_control[1:0] != ioirq_pkg::SKCTL_RESET_MODE)
                begin
                    if (chip.out_ready_count != 0)
                    begin
                        chip.out_ready_count = chip.out_ready_count - 1'b1;
                        if (chip.out_ready_count == 0 &&
                            chip.irq_enable[ioirq_pkg::IRQ_OUTRDY_BIT])
                        begin
                            chip.irq_status[ioirq_pkg::IRQ_OUTRDY_BIT] = 1'b0;
                            chip.irq_line = 1'b1;
                        end
                    end
                    if (chip.xmit_done_count != 0)
                    begin
                        chip.xmit_done_count = chip.xmit_done_count - 1'b1;
                        if (chip.xmit_done_count == 0)
                        begin
                            chip.irq_status[ioirq_pkg::IRQ_XMIT_BIT] = 1'b0;
                            if (chip.irq_enable[ioirq_pkg::IRQ_XMIT_BIT])
                                chip.irq_line = 1'b1;
                        end
                    end
                end
            end
            ioirq_pkg::OP_KEY:
            begin
                chip.key_code = r.item_data;
                if (chip.irq_enable[ioirq_pkg::IRQ_KEY_BIT])
                begin
                    chip.irq_status[ioirq_pkg::IRQ_KEY_BIT] = 1'b0;
                    chip.irq_line = 1'b1;
                end
            end
            ioirq_pkg::OP_BREAK:
            begin
                if (chip.irq_enable[ioirq_pkg::IRQ_BREAK_BIT])
                begin
                    chip.irq_status[ioirq_pkg::IRQ_BREAK_BIT] = 1'b0;
                    chip.irq_line = 1'b1;
                end
            end
            default: ;
        endcase
        rep.irq_out = chip.irq_line;
        return rep;
    endfunction

    task automatic enqueue_access(input logic [ioirq_pkg::OP_W-1:0] op,
                                  input logic [ioirq_pkg::ADDR_W-1:0] addr,
                                  input logic [ioirq_pkg::DATA_W-1:0] data);
        ioirq_pkg::request_t r;
        r.operation        = op;
        r.register_address = addr;
        r.item_data        = data;
        pending_requests.push_back(r);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.operation = '0;
        req.register_address = '0;
        req.item_data = '0;
        rsp.ready = 1'b0;
        accepted_requests = 0;
        mismatches = 0;
        quiet_cycles = 0;
        chip = '0;
        clear_chip_block();
        fork
            forever #5 clk = ~clk;
            begin
                repeat (5) @(posedge clk);
                rst_n <= 1'b1;
            end
        join_none
    end

    initial
    begin
        logic [ioirq_pkg::DATA_W-1:0] d;
        int span;
        int roll;
        int target;

        enqueue_access(ioirq_pkg::OP_READ, ioirq_pkg::REG_IRQST, 8'h00);
        enqueue_access(ioirq_pkg::OP_READ, ioirq_pkg::REG_SKSTAT, 8'hFF);
        enqueue_access(ioirq_pkg::OP_READ, ioirq_pkg::REG_RANDOM, 8'h00);
        enqueue_access(ioirq_pkg::OP_READ, ioirq_pkg::REG_RANDOM, 8'h00);
        enqueue_access(ioirq_pkg::OP_READ, REG_SPARE, 8'h00);
        enqueue_access(ioirq_pkg::OP_READ, ioirq_pkg::REG_POT0, 8'h00);
        // serial out while in reset mode: ticks must be ignored
        enqueue_access(ioirq_pkg::OP_WRITE, ioirq_pkg::REG_SEROUT, 8'hFF);
        enqueue_access(ioirq_pkg::OP_TICK, ioirq_pkg::REG_POT0, 8'h00);
        enqueue_access(ioirq_pkg::OP_WRITE, ioirq_pkg::REG_SKCTL, 8'h03);
        enqueue_access(ioirq_pkg::OP_WRITE, ioirq_pkg::REG_IRQEN, 8'hFF);
        enqueue_access(ioirq_pkg::OP_KEY, ioirq_pkg::REG_POT0, 8'hFF);
        enqueue_access(ioirq_pkg::OP_READ, ioirq_pkg::REG_KBCODE, 8'h00);
        enqueue_access(ioirq_pkg::OP_BREAK, ioirq_pkg::REG_SKCTL, 8'h00);
        enqueue_access(ioirq_pkg::OP_READ, ioirq_pkg::REG_IRQST, 8'h00);
        // drop the line through the enable register
        enqueue_access(ioirq_pkg::OP_WRITE, ioirq_pkg::REG_IRQEN, 8'h00);
        enqueue_access(ioirq_pkg::OP_KEY, ioirq_pkg::REG_SKCTL, 8'h00);
        enqueue_access(OP_SPARE_FIRST, ioirq_pkg::REG_SKCTL, 8'hFF);
        enqueue_access(OP_SPARE_LAST, ioirq_pkg::REG_POT0, 8'h00);
        enqueue_access(ioirq_pkg::OP_WRITE, ioirq_pkg::REG_SKREST, 8'h00);
        enqueue_access(ioirq_pkg::OP_WRITE, REG_SPARE, 8'hFF);
        // block reset through serial control
        enqueue_access(ioirq_pkg::OP_WRITE, ioirq_pkg::REG_SKCTL, 8'hFC);
        enqueue_access(ioirq_pkg::OP_READ, ioirq_pkg::REG_RANDOM, 8'h00);
        enqueue_access(ioirq_pkg::OP_TICK, ioirq_pkg::REG_POT0, 8'h00);
        enqueue_access(ioirq_pkg::OP_READ, ioirq_pkg::REG_SKSTAT, 8'h00);

        target = pending_requests.size() + RANDOM_ITEMS;
        while (pending_requests.size() < target)
        begin
            // start a serial transfer with its delay interrupts mostly enabled, then send mostly tick requests
            d = 8'($urandom_range(255, 0));
            if (d[1:0] == ioirq_pkg::SKCTL_RESET_MODE)
                d[1:0] = 2'($urandom_range(3, 1));
            enqueue_access(ioirq_pkg::OP_WRITE, ioirq_pkg::REG_SKCTL, d);
            d = 8'($urandom_range(255, 0));
            if ($urandom_range(3, 0) != 0)
                d[ioirq_pkg::IRQ_OUTRDY_BIT] = 1'b1;
            if ($urandom_range(3, 0) != 0)
                d[ioirq_pkg::IRQ_XMIT_BIT] = 1'b1;
            enqueue_access(ioirq_pkg::OP_WRITE, ioirq_pkg::REG_IRQEN, d);
            enqueue_access(ioirq_pkg::OP_WRITE, ioirq_pkg::REG_SEROUT,
                           8'($urandom_range(255, 0)));
            span = $urandom_range(140, 95);
            repeat (span)
            begin
                roll = $urandom_range(99, 0);
                if (roll < 80)
                    enqueue_access(ioirq_pkg::OP_TICK, 4'($urandom_range(15, 0)),
                                   8'($urandom_range(255, 0)));
                else if (roll < 86)
                    enqueue_access(ioirq_pkg::OP_READ, 4'($urandom_range(15, 0)),
                                   8'($urandom_range(255, 0)));
                else if (roll < 90)
                    enqueue_access(ioirq_pkg::OP_KEY, 4'($urandom_range(15, 0)),
                                   8'($urandom_range(255, 0)));
                else if (roll < 93)
                    enqueue_access(ioirq_pkg::OP_BREAK, 4'($urandom_range(15, 0)),
                                   8'($urandom_range(255, 0)));
                else if (roll < 96)
                    enqueue_access(ioirq_pkg::OP_WRITE, ioirq_pkg::REG_IRQEN,
                                   8'($urandom_range(255, 0)));
                else if (roll < 98)
                    enqueue_access(ioirq_pkg::OP_WRITE, ioirq_pkg::REG_SEROUT,
                                   8'($urandom_range(255, 0)));
                else
                    enqueue_access(3'($urandom_range(7, 0)), 4'($urandom_range(15, 0)),
                                   8'($urandom_range(255, 0)));
            end
            span = $urandom_range(40, 10);
            repeat (span)
                enqueue_access(3'($urandom_range(7, 0)), 4'($urandom_range(15, 0)),
                               8'($urandom_range(255, 0)));
        end

        wait (rst_n === 1'b1);
        while (pending_requests.size() != 0 || req.valid || due_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        ioirq_pkg::request_t next_req;
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.operation <= '0;
            req.register_address <= '0;
            req.item_data <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                due_replies.push_back(step_chip({req.operation, req.register_address,
                                                 req.item_data}));
                accepted_requests <= accepted_requests + 1;
            end
            if (!req.valid || req.ready)
            begin
                if (pending_requests.size() != 0 && (steady || $urandom_range(99, 0) >= 25))
                begin
                    next_req = pending_requests.pop_front();
                    req.valid <= 1'b1;
                    req.operation <= next_req.operation;
                    req.register_address <= next_req.register_address;
                    req.item_data <= next_req.item_data;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_replies
        reply_t want;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_replies.size() == 0)
                begin
                    $display("%0t: unexpected reply, expected none, actual read_data %h irq %b",
                             $time, rsp.read_data, rsp.irq_out);
                    mismatches++;
                end
                else
                begin
                    want = due_replies.pop_front();
                    if (rsp.read_data !== want.read_data)
                    begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, rsp.read_data);
                        mismatches++;
                    end
                    if (rsp.irq_out !== want.irq_out)
                    begin
                        $display("%0t: irq_out expected %b actual %b",
                                 $time, want.irq_out, rsp.irq_out);
                        mismatches++;
                    end
                end
            end
            rsp.ready <= steady || ($urandom_range(99, 0) >= 25);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end
endmodule
`default_nettype wire
